[rtl/triangle_tangent_basis_core_assert.svh]
// assertion macros for the triangle tangent basis core
// expects clk and arst_n in the scope of every use
`ifndef TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_CORE_ASSERT_SVH

// same-cycle implication
`define TTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ttb_pkg.sv]
// shared types and constants of the triangle tangent basis core
// no dependencies
package ttb_pkg;

	localparam int IN_W    = 32;
	localparam int OUT_W   = 16;
	localparam int DIGIT_W = 8;

	typedef struct packed {
		logic start;
		logic neg;
	} norm_ctrl_t;

endpackage

[rtl/triangle_tangent_basis_core.sv]
// triangle tangent basis core: top level with corner store and sequencer
// depends on ttb_pkg, ttb_mul, ttb_norm and triangle_tangent_basis_core_assert.svh
//
// Corners arrive one beat at a time on the input channel (in_valid/in_stall), each
// with a Q16.16 position and texture coordinate. The first two beats of a triangle
// are stored and accepted at once. The third beat starts the computation and the
// block holds in_stall high until the result register is loaded.
// One result beat (tangent, binormal, face normal, Q1.14) follows every third corner
// on the output channel (out_valid/out_stall).
// After the third corner, all twenty products and nine squares go through
// one shared multiplier taking one 8-bit digit per cycle, and each of the nine
// components is then resolved one bit a cycle by the normaliser.
// While a result waits under out_stall the first two corners of the next triangle
// are still accepted; the third is held off until the result beat is taken.
// Reset clears the corner count and the output valid; stored corners are left as is.
module triangle_tangent_basis_core #(
	parameter int COORD_BITS    = 32,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [ttb_pkg::IN_W-1:0]    pos_x,
	input  logic signed [ttb_pkg::IN_W-1:0]    pos_y,
	input  logic signed [ttb_pkg::IN_W-1:0]    pos_z,
	input  logic signed [ttb_pkg::IN_W-1:0]    tex_u,
	input  logic signed [ttb_pkg::IN_W-1:0]    tex_v,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ttb_pkg::OUT_W-1:0]   tangent_x,
	output logic signed [ttb_pkg::OUT_W-1:0]   tangent_y,
	output logic signed [ttb_pkg::OUT_W-1:0]   tangent_z,
	output logic signed [ttb_pkg::OUT_W-1:0]   binormal_x,
	output logic signed [ttb_pkg::OUT_W-1:0]   binormal_y,
	output logic signed [ttb_pkg::OUT_W-1:0]   binormal_z,
	output logic signed [ttb_pkg::OUT_W-1:0]   normal_x,
	output logic signed [ttb_pkg::OUT_W-1:0]   normal_y,
	output logic signed [ttb_pkg::OUT_W-1:0]   normal_z
);

	`include "triangle_tangent_basis_core_assert.svh"

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int V  = 2*D + 1;
	localparam int PW = 2*V;
	localparam int SW = PW + 2;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_PROD_GO   = 3'd1;
	localparam logic [2:0] ST_PROD_WAIT = 3'd2;
	localparam logic [2:0] ST_SQ_GO     = 3'd3;
	localparam logic [2:0] ST_SQ_WAIT   = 3'd4;
	localparam logic [2:0] ST_NORM_GO   = 3'd5;
	localparam logic [2:0] ST_NORM_WAIT = 3'd6;

	localparam logic [4:0] LAST_STEP = 5'd19;

	logic [2:0] state_q;
	logic [1:0] cnt_q;
	logic [4:0] step_q;
	logic [1:0] grp_q;
	logic [1:0] k_q;
	logic       out_valid_q;
	logic       det_zero_q;
	logic       det_neg_q;

	logic signed [C-1:0] p0_q [3];
	logic signed [C-1:0] p1_q [3];
	logic signed [C-1:0] uv0_q [2];
	logic signed [C-1:0] uv1_q [2];
	logic signed [D-1:0] dv0_q [3];
	logic signed [D-1:0] dv1_q [3];
	logic signed [D-1:0] dt0u_q, dt0v_q, dt1u_q, dt1v_q;
	logic signed [V-1:0] hold_q;
	logic signed [V-1:0] vec_q [9];
	logic [PW-1:0]       sq_q [3];
	logic [SW-1:0]       sum_q;
	logic [ttb_pkg::OUT_W-1:0] res_q [9];

	logic signed [C-1:0] pin [3];
	logic signed [C-1:0] uvin [2];
	logic                accept_in;
	logic                out_take;

	logic signed [D-1:0] a0, b0, a1, b1;
	logic signed [D-1:0] pa, pb;
	logic [3:0]          idx;
	logic signed [V-1:0] comp;
	logic                tb_grp;
	logic signed [V-1:0] mul_a, mul_b;
	logic                mul_start;
	logic                mul_done;
	logic signed [PW-1:0] mul_prod;
	logic signed [V-1:0] diff;
	logic [3:0]          pair;

	ttb_pkg::norm_ctrl_t       norm_ctrl;
	logic                      norm_done;
	logic [ttb_pkg::OUT_W-1:0] norm_res;

	assign pin[0]  = pos_x[C-1:0];
	assign pin[1]  = pos_y[C-1:0];
	assign pin[2]  = pos_z[C-1:0];
	assign uvin[0] = tex_u[C-1:0];
	assign uvin[1] = tex_v[C-1:0];

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && cnt_q[1]);
	assign accept_in = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	// operand pairs of each cross product: first minus second
	assign pair = step_q[4:1];
	always_comb begin
		a0 = dt0u_q; b0 = dt1v_q; a1 = dt1u_q; b1 = dt0v_q;
		unique case (pair)
			4'd0: begin
				a0 = dt0u_q; b0 = dt1v_q; a1 = dt1u_q; b1 = dt0v_q;
			end
			4'd1: begin
				a0 = dt1v_q; b0 = dv0_q[0]; a1 = dt0v_q; b1 = dv1_q[0];
			end
			4'd2: begin
				a0 = dt1v_q; b0 = dv0_q[1]; a1 = dt0v_q; b1 = dv1_q[1];
			end
			4'd3: begin
				a0 = dt1v_q; b0 = dv0_q[2]; a1 = dt0v_q; b1 = dv1_q[2];
			end
			4'd4: begin
				a0 = dt0u_q; b0 = dv1_q[0]; a1 = dt1u_q; b1 = dv0_q[0];
			end
			4'd5: begin
				a0 = dt0u_q; b0 = dv1_q[1]; a1 = dt1u_q; b1 = dv0_q[1];
			end
			4'd6: begin
				a0 = dt0u_q; b0 = dv1_q[2]; a1 = dt1u_q; b1 = dv0_q[2];
			end
			4'd7: begin
				a0 = dv0_q[1]; b0 = dv1_q[2]; a1 = dv0_q[2]; b1 = dv1_q[1];
			end
			4'd8: begin
				a0 = dv0_q[2]; b0 = dv1_q[0]; a1 = dv0_q[0]; b1 = dv1_q[2];
			end
			4'd9: begin
				a0 = dv0_q[0]; b0 = dv1_q[1]; a1 = dv0_q[1]; b1 = dv1_q[0];
			end
			default: begin
				a0 = dt0u_q; b0 = dt1v_q; a1 = dt1u_q; b1 = dt0v_q;
			end
		endcase
	end

	assign pa = step_q[0] ? a1 : a0;
	assign pb = step_q[0] ? b1 : b0;

	// tangent and binormal groups vanish on a zero uv determinant
	assign idx    = 4'(grp_q) * 4'd3 + 4'(k_q);
	assign tb_grp = (grp_q != 2'd2);
	assign comp   = (tb_grp && det_zero_q) ? '0 : vec_q[idx];

	always_comb begin
		if (state_q == ST_PROD_GO || state_q == ST_PROD_WAIT) begin
			mul_a = {{(V-D){pa[D-1]}}, pa};
			mul_b = {{(V-D){pb[D-1]}}, pb};
		end else begin
			mul_a = comp;
			mul_b = comp;
		end
	end

	assign mul_start = (state_q == ST_PROD_GO) || (state_q == ST_SQ_GO);
	assign diff      = hold_q - mul_prod[V-1:0];

	assign norm_ctrl.start = (state_q == ST_NORM_GO) && (sum_q != '0);
	assign norm_ctrl.neg   = comp[V-1] ^ (tb_grp && det_neg_q);

	ttb_mul #(
		.W (V)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ttb_norm #(
		.SW (SW),
		.F  (OUT_FRAC_BITS)
	) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (norm_ctrl),
		.sum    (sum_q),
		.sq     ({2'b00, sq_q[k_q]}),
		.done   (norm_done),
		.res    (norm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 2'd0;
			step_q      <= '0;
			grp_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept_in) begin
						case (cnt_q)
							2'd0: cnt_q <= 2'd1;
							2'd1: cnt_q <= 2'd2;
							default: begin
								cnt_q   <= 2'd0;
								step_q  <= '0;
								state_q <= ST_PROD_GO;
							end
						endcase
					end
				end
				ST_PROD_GO: state_q <= ST_PROD_WAIT;
				ST_PROD_WAIT: begin
					if (mul_done) begin
						if (step_q == LAST_STEP) begin
							grp_q   <= '0;
							k_q     <= '0;
							state_q <= ST_SQ_GO;
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= ST_PROD_GO;
						end
					end
				end
				ST_SQ_GO: state_q <= ST_SQ_WAIT;
				ST_SQ_WAIT: begin
					if (mul_done) begin
						if (k_q == 2'd2) begin
							k_q     <= '0;
							state_q <= ST_NORM_GO;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_SQ_GO;
						end
					end
				end
				ST_NORM_GO, ST_NORM_WAIT: begin
					if ((state_q == ST_NORM_GO && sum_q == '0) ||
					    (state_q == ST_NORM_WAIT && norm_done)) begin
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (grp_q == 2'd2) begin
								out_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								grp_q   <= grp_q + 2'd1;
								state_q <= ST_SQ_GO;
							end
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_NORM_GO;
						end
					end else if (state_q == ST_NORM_GO) begin
						state_q <= ST_NORM_WAIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			case (cnt_q)
				2'd0: begin
					p0_q  <= pin;
					uv0_q <= uvin;
				end
				2'd1: begin
					p1_q  <= pin;
					uv1_q <= uvin;
				end
				default: begin
					for (int i = 0; i < 3; i++) begin
						dv0_q[i] <= {p1_q[i][C-1], p1_q[i]} - {p0_q[i][C-1], p0_q[i]};
						dv1_q[i] <= {pin[i][C-1], pin[i]} - {p0_q[i][C-1], p0_q[i]};
					end
					dt0u_q <= {uv1_q[0][C-1], uv1_q[0]} - {uv0_q[0][C-1], uv0_q[0]};
					dt0v_q <= {uv1_q[1][C-1], uv1_q[1]} - {uv0_q[1][C-1], uv0_q[1]};
					dt1u_q <= {uvin[0][C-1], uvin[0]} - {uv0_q[0][C-1], uv0_q[0]};
					dt1v_q <= {uvin[1][C-1], uvin[1]} - {uv0_q[1][C-1], uv0_q[1]};
				end
			endcase
		end
		if (state_q == ST_PROD_WAIT && mul_done) begin
			if (!step_q[0]) begin
				hold_q <= mul_prod[V-1:0];
			end else if (pair == 4'd0) begin
				det_zero_q <= (diff == '0);
				det_neg_q  <= diff[V-1];
			end else begin
				vec_q[pair - 4'd1] <= diff;
			end
		end
		if (state_q == ST_SQ_GO && k_q == 2'd0) begin
			sum_q <= '0;
		end
		if (state_q == ST_SQ_WAIT && mul_done) begin
			sq_q[k_q] <= mul_prod[PW-1:0];
			sum_q     <= sum_q + {2'b00, mul_prod[PW-1:0]};
		end
		if (state_q == ST_NORM_GO && sum_q == '0) begin
			res_q[idx] <= '0;
		end
		if (state_q == ST_NORM_WAIT && norm_done) begin
			res_q[idx] <= norm_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign tangent_x  = res_q[0];
	assign tangent_y  = res_q[1];
	assign tangent_z  = res_q[2];
	assign binormal_x = res_q[3];
	assign binormal_y = res_q[4];
	assign binormal_z = res_q[5];
	assign normal_x   = res_q[6];
	assign normal_y   = res_q[7];
	assign normal_z   = res_q[8];

	`TTB_ASSERT_IMP(a_mul_done_phase, mul_done, (state_q == ST_PROD_WAIT) || (state_q == ST_SQ_WAIT), "multiplier finished outside a product or square phase")
	`TTB_ASSERT_IMP(a_norm_done_phase, norm_done, state_q == ST_NORM_WAIT, "normaliser finished outside its phase")
	`TTB_ASSERT_NXT(a_third_starts, accept_in && cnt_q[1], state_q == ST_PROD_GO, "third corner beat did not start the triangle")
	`TTB_ASSERT_IMP(a_result_after_triangle, $rose(out_valid_q), cnt_q == 2'd0, "result beat raised in the middle of a triangle")

endmodule

[rtl/ttb_mul.sv]
// shared signed multiplier, one 8-bit digit of the multiplier per cycle
// depends on ttb_pkg
module ttb_mul #(
	parameter int W = 67
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic                  done,
	output logic signed [2*W-1:0] prod
);

	localparam int D = ttb_pkg::DIGIT_W;
	localparam logic [1:0] MS_IDLE = 2'd0;
	localparam logic [1:0] MS_RUN  = 2'd1;
	localparam logic [1:0] MS_FIX  = 2'd2;

	logic [1:0]       st_q;
	logic [2*W-1:0]   ash_q;
	logic [2*W-1:0]   acc_q;
	logic [W-1:0]     brem_q;
	logic             neg_q;
	logic             done_q;
	logic [2*W-1:0]   prod_q;
	logic [W-1:0]     am;
	logic [W-1:0]     bm;
	logic [2*W+D-1:0] pp;

	assign am = a[W-1] ? (~a + W'(1)) : a;
	assign bm = b[W-1] ? (~b + W'(1)) : b;
	assign pp = ash_q * brem_q[D-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MS_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				MS_IDLE: begin
					if (start) begin
						st_q <= MS_RUN;
					end
				end
				MS_RUN: begin
					if (brem_q == '0) begin
						st_q <= MS_FIX;
					end
				end
				MS_FIX: begin
					st_q   <= MS_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == MS_IDLE && start) begin
			ash_q  <= {{W{1'b0}}, am};
			brem_q <= bm;
			acc_q  <= '0;
			neg_q  <= a[W-1] ^ b[W-1];
		end else if (st_q == MS_RUN && brem_q != '0) begin
			acc_q  <= acc_q + pp[2*W-1:0];
			ash_q  <= ash_q << D;
			brem_q <= brem_q >> D;
		end
		if (st_q == MS_FIX) begin
			prod_q <= neg_q ? (~acc_q + (2*W)'(1)) : acc_q;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

[rtl/ttb_norm.sv]
// bit-serial normaliser: largest q with (2q-1)^2 * sum <= c^2 * 4^(F+1)
// depends on ttb_pkg
module ttb_norm #(
	parameter int SW = 136,
	parameter int F  = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ttb_pkg::norm_ctrl_t        ctrl,
	input  logic [SW-1:0]              sum,
	input  logic [SW-1:0]              sq,
	output logic                       done,
	output logic [ttb_pkg::OUT_W-1:0]  res
);

	localparam int NW = SW + 2*F + 4;
	localparam int QW = F + 1;
	localparam int BW = $clog2(QW);
	localparam int RW = F + ttb_pkg::OUT_W + 1;

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [NW-1:0]     a_q;
	logic signed [NW:0] bs_q;
	logic [NW-1:0]     ss_q;
	logic [NW-1:0]     rr_q;
	logic [QW-1:0]     r_q;
	logic [BW-1:0]     bit_q;
	logic [ttb_pkg::OUT_W-1:0] res_q;

	logic [NW:0]          bs_base;
	logic signed [NW+1:0] lhs;
	logic signed [NW+1:0] bs_up;
	logic                 take;
	logic [QW-1:0]        r_next;
	logic [RW-1:0]        qx;
	logic [RW-1:0]        qs;

	assign bs_base = {{(NW+1-SW){1'b0}}, sum} << (F + 2);
	assign lhs = $signed({2'b00, a_q}) + $signed({bs_q[NW], bs_q}) + $signed({2'b00, ss_q});
	assign bs_up = $signed({bs_q[NW], bs_q}) + $signed({1'b0, ss_q, 1'b0});
	assign take = !r_q[F] && (lhs[NW+1:0] <= $signed({2'b00, rr_q}));
	assign r_next = take ? (r_q | (QW'(1) << bit_q)) : r_q;
	assign qx = {{(RW-QW){1'b0}}, r_next};
	assign qs = neg_q ? (~qx + RW'(1)) : qx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				busy_q <= ctrl.start;
			end else if (bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && ctrl.start) begin
			a_q   <= {{(NW-SW){1'b0}}, sum};
			ss_q  <= {{(NW-SW){1'b0}}, sum} << (2*F + 2);
			rr_q  <= {{(NW-SW){1'b0}}, sq} << (2*F + 2);
			bs_q  <= $signed(~bs_base + (NW+1)'(1));
			r_q   <= '0;
			bit_q <= BW'(F);
			neg_q <= ctrl.neg;
		end else if (busy_q) begin
			// accepted bit folds 2*ss into the cross term before both step down
			if (take) begin
				a_q  <= lhs[NW-1:0];
				bs_q <= bs_up[NW+1:1];
			end else begin
				bs_q <= bs_q >>> 1;
			end
			ss_q  <= ss_q >> 2;
			r_q   <= r_next;
			bit_q <= bit_q - BW'(1);
			if (bit_q == '0) begin
				res_q <= qs[ttb_pkg::OUT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[tb/tb.sv]
// testbench for triangle_tangent_basis_core: corner beats in, basis beats checked
// against a wide-integer model of tangent, binormal and normal; depends on ttb_pkg
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] wide_t;
	typedef logic signed [ttb_pkg::IN_W-1:0] coord_t;
	typedef logic signed [ttb_pkg::OUT_W-1:0] comp_t;

	typedef struct {
		comp_t tan[3];
		comp_t bin[3];
		comp_t nrm[3];
	} basis_t;

	typedef struct {
		coord_t p[3];
		coord_t uv[2];
	} corner_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t pos_x, pos_y, pos_z, tex_u, tex_v;
	logic out_valid;
	logic out_stall;
	comp_t tangent_x, tangent_y, tangent_z;
	comp_t binormal_x, binormal_y, binormal_z;
	comp_t normal_x, normal_y, normal_z;

	basis_t basis_q[$];
	corner_t held[2];
	int unsigned held_count;
	int unsigned errors;
	bit idle_on;
	bit long_hold_req;
	int unsigned hold_cycles;

	triangle_tangent_basis_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.out_valid(out_valid), .out_stall(out_stall),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.binormal_x(binormal_x), .binormal_y(binormal_y), .binormal_z(binormal_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one component of a unit vector: largest q with (q - 1/2) <= |c| * 2^14 / |v|
	function automatic comp_t unit_comp(wide_t c, wide_t sumsq);
		wide_t mag;
		wide_t rhs;
		wide_t lhs;
		wide_t odd;
		int unsigned q;
		int unsigned cand;
		if (sumsq == 0)
			return '0;
		mag = (c < 0) ? -c : c;
		rhs = (mag * mag) <<< 30;
		q = 0;
		for (int b = 14; b >= 0; b--) begin
			cand = q | (1 << b);
			if (cand > 16384)
				continue;
			odd = wide_t'(2 * cand - 1);
			lhs = odd * odd * sumsq;
			if (lhs <= rhs)
				q = cand;
		end
		return (c < 0) ? comp_t'(-q) : comp_t'(q);
	endfunction

	function automatic void unit_vec(input wide_t v[3], output comp_t r[3]);
		wide_t sumsq;
		sumsq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		for (int k = 0; k < 3; k++)
			r[k] = unit_comp(v[k], sumsq);
	endfunction

	function automatic basis_t triangle_basis(corner_t a, corner_t b, corner_t c);
		basis_t r;
		wide_t dv0[3], dv1[3], t[3], bn[3], n[3];
		wide_t d0u, d0v, d1u, d1v, det;
		for (int k = 0; k < 3; k++) begin
			dv0[k] = wide_t'(b.p[k]) - wide_t'(a.p[k]);
			dv1[k] = wide_t'(c.p[k]) - wide_t'(a.p[k]);
		end
		d0u = wide_t'(b.uv[0]) - wide_t'(a.uv[0]);
		d0v = wide_t'(b.uv[1]) - wide_t'(a.uv[1]);
		d1u = wide_t'(c.uv[0]) - wide_t'(a.uv[0]);
		d1v = wide_t'(c.uv[1]) - wide_t'(a.uv[1]);
		det = d0u * d1v - d1u * d0v;
		for (int k = 0; k < 3; k++) begin
			if (det == 0) begin
				t[k] = '0;
				bn[k] = '0;
			end else begin
				t[k] = d1v * dv0[k] - d0v * dv1[k];
				bn[k] = d0u * dv1[k] - d1u * dv0[k];
				if (det < 0) begin
					t[k] = -t[k];
					bn[k] = -bn[k];
				end
			end
		end
		n[0] = dv0[1] * dv1[2] - dv0[2] * dv1[1];
		n[1] = dv0[2] * dv1[0] - dv0[0] * dv1[2];
		n[2] = dv0[0] * dv1[1] - dv0[1] * dv1[0];
		unit_vec(t, r.tan);
		unit_vec(bn, r.bin);
		unit_vec(n, r.nrm);
		return r;
	endfunction

	task automatic send_corner(coord_t x, coord_t y, coord_t z, coord_t u, coord_t v);
		corner_t cn;
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		tex_u <= u;
		tex_v <= v;
		do @(posedge clk); while (in_stall);
		cn.p[0] = x;
		cn.p[1] = y;
		cn.p[2] = z;
		cn.uv[0] = u;
		cn.uv[1] = v;
		if (held_count < 2) begin
			held[held_count] = cn;
			held_count++;
		end else begin
			basis_q.push_back(triangle_basis(held[0], held[1], cn));
			held_count = 0;
		end
	endtask

	function automatic coord_t pick_coord(int unsigned mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 16'hffff)) - 32768);
			2: return coord_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000) <<< 8;
			default: return coord_t'($urandom_range(0, 7)) <<< 16;
		endcase
	endfunction

	task automatic send_random_triangle();
		int unsigned mode;
		mode = $urandom_range(0, 3);
		repeat (3)
			send_corner(pick_coord(mode), pick_coord(mode), pick_coord(mode),
				pick_coord(mode), pick_coord(mode));
	endtask

	task automatic wait_drained();
		while (basis_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		localparam coord_t ONE = 32'sh0001_0000;
		localparam coord_t MAXC = 32'sh7fff_ffff;
		localparam coord_t MINC = 32'sh8000_0000;
		// flat unit triangle in the xy plane, positive uv winding
		send_corner(0, 0, 0, 0, 0);
		send_corner(ONE, 0, 0, ONE, 0);
		send_corner(0, ONE, 0, 0, ONE);
		// same with mirrored uv: determinant negative
		send_corner(0, 0, 0, 0, 0);
		send_corner(ONE, 0, 0, 0, ONE);
		send_corner(0, ONE, 0, ONE, 0);
		// collapsed triangle: every vector zero
		repeat (3) send_corner(ONE, -ONE, 7, 3, 3);
		// uv all on one line: zero determinant, normal still valid
		send_corner(0, 0, 0, 0, 0);
		send_corner(ONE, 0, 0, ONE, ONE);
		send_corner(0, 0, ONE, 2 * ONE, 2 * ONE);
		// extremes of the coordinate range
		send_corner(MINC, MINC, MINC, MINC, MINC);
		send_corner(MAXC, MINC, MAXC, MAXC, MINC);
		send_corner(MINC, MAXC, MAXC, MINC, MAXC);
		send_corner(MAXC, MAXC, MAXC, MAXC, MAXC);
		send_corner(MINC, 0, -1, 0, MAXC);
		send_corner(-1, MAXC, 1, MINC, -1);
		// diagonal: components of 1/sqrt(2) and 1/sqrt(3), between neighbouring codes
		send_corner(0, 0, 0, 0, 0);
		send_corner(1, 1, 0, 1, 0);
		send_corner(0, 1, 1, 0, 1);
	endtask

	task automatic test_back_pressure();
		long_hold_req = 1'b1;
		repeat (4) send_random_triangle();
	endtask

	task automatic test_drain_pause();
		in_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		repeat (3) send_random_triangle();
	endtask

	task automatic test_random(int unsigned n_tri);
		repeat (n_tri) send_random_triangle();
	endtask

	// receiver: random stall bursts, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_hold_req) begin
			out_stall <= 1'b1;
			hold_cycles <= 1500;
			long_hold_req <= 1'b0;
		end else if (hold_cycles != 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (idle_on && !out_stall && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			hold_cycles <= $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result beat checker
	always @(posedge clk) begin
		basis_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (basis_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = basis_q.pop_front();
				if (tangent_x !== e.tan[0]) begin
					$error("tangent_x exp %0d got %0d", e.tan[0], tangent_x);
					errors++;
				end
				if (tangent_y !== e.tan[1]) begin
					$error("tangent_y exp %0d got %0d", e.tan[1], tangent_y);
					errors++;
				end
				if (tangent_z !== e.tan[2]) begin
					$error("tangent_z exp %0d got %0d", e.tan[2], tangent_z);
					errors++;
				end
				if (binormal_x !== e.bin[0]) begin
					$error("binormal_x exp %0d got %0d", e.bin[0], binormal_x);
					errors++;
				end
				if (binormal_y !== e.bin[1]) begin
					$error("binormal_y exp %0d got %0d", e.bin[1], binormal_y);
					errors++;
				end
				if (binormal_z !== e.bin[2]) begin
					$error("binormal_z exp %0d got %0d", e.bin[2], binormal_z);
					errors++;
				end
				if (normal_x !== e.nrm[0]) begin
					$error("normal_x exp %0d got %0d", e.nrm[0], normal_x);
					errors++;
				end
				if (normal_y !== e.nrm[1]) begin
					$error("normal_y exp %0d got %0d", e.nrm[1], normal_y);
					errors++;
				end
				if (normal_z !== e.nrm[2]) begin
					$error("normal_z exp %0d got %0d", e.nrm[2], normal_z);
					errors++;
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("** triangle_tangent_basis_core: FAILED **");
		$finish;
	end

	initial begin
		errors = 0;
		held_count = 0;
		hold_cycles = 0;
		long_hold_req = 1'b0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		tex_u = '0;
		tex_v = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_drain_pause();
		test_random(180);
		idle_on = 1'b0;
		test_random(30);
		in_valid <= 1'b0;
		wait_drained();
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("** triangle_tangent_basis_core: PASSED **");
		else
			$display("** triangle_tangent_basis_core: FAILED **");
		$finish;
	end
endmodule
